FILE: hdl/vtese_pkg.sv
// shared types, constants and the sequence script table for the escape sequence encoder
`timescale 1ns / 1ps
`default_nettype none

package vtese_pkg;

    localparam int PC_W = 6;
    localparam int NUM_W = 16;
    localparam int ATTR_N = 5;
    localparam int ATTR_IDX_W = 3;
    localparam int DIG_N = 5;
    localparam int DIG_CNT_W = 3;

    localparam logic [2:0] OP_RESET = 3'd0;
    localparam logic [2:0] OP_POSITION = 3'd1;
    localparam logic [2:0] OP_COLOR = 3'd2;
    localparam logic [2:0] OP_ATTR = 3'd3;
    localparam logic [2:0] OP_SHOW = 3'd4;
    localparam logic [2:0] OP_HIDE = 3'd5;

    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_LBRK = 8'h5b;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam logic [7:0] CODE_FG_TRUE = 8'd38;
    localparam logic [7:0] CODE_FG_DEF = 8'd39;
    localparam logic [7:0] CODE_BG_TRUE = 8'd48;
    localparam logic [7:0] CODE_BG_DEF = 8'd49;

    localparam logic [4:0] ATTR_ON_CODE [ATTR_N] = '{5'd1, 5'd3, 5'd4, 5'd7, 5'd9};
    localparam logic [4:0] ATTR_OFF_CODE [ATTR_N] = '{5'd22, 5'd23, 5'd24, 5'd27, 5'd29};

    localparam logic [PC_W-1:0] PC_RESET = 6'd0;
    localparam logic [PC_W-1:0] PC_POS = 6'd3;
    localparam logic [PC_W-1:0] PC_SHOW = 6'd9;
    localparam logic [PC_W-1:0] PC_HIDE = 6'd26;
    localparam logic [PC_W-1:0] PC_CDEF = 6'd32;
    localparam logic [PC_W-1:0] PC_CTRUE = 6'd36;
    localparam logic [PC_W-1:0] PC_ATTR = 6'd48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RUN,
        ST_CONV,
        ST_DIGITS
    } t_state;

    typedef enum logic [1:0] {
        UOP_BYTE,
        UOP_NUM,
        UOP_ATTR_M
    } t_uop_kind;

    typedef enum logic [2:0] {
        NUM_ROW,
        NUM_COL,
        NUM_STYLE,
        NUM_CCODE,
        NUM_RED,
        NUM_GREEN,
        NUM_BLUE,
        NUM_ATTR
    } t_num_sel;

    typedef struct packed {
        t_uop_kind kind;
        t_num_sel  sel;
        logic [7:0] ch;
        logic       last;
    } t_uop;

    typedef struct packed {
        logic                  load;
        logic                  conv_start;
        t_num_sel              num_sel;
        logic [ATTR_IDX_W-1:0] attr_idx;
        logic                  emit;
        logic                  emit_digit;
        logic [7:0]            ch;
        logic                  last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0]        op;
        logic              alpha_zero;
        logic [ATTR_N-1:0] diff;
        logic              out_free;
        logic              conv_busy;
        logic              dig_last;
    } t_dp_stat;

    function automatic t_uop uop_b(input logic [7:0] ch, input logic last);
        t_uop u;
        u.kind = UOP_BYTE;
        u.sel = NUM_ROW;
        u.ch = ch;
        u.last = last;
        return u;
    endfunction

    function automatic t_uop uop_n(input t_num_sel sel);
        t_uop u;
        u.kind = UOP_NUM;
        u.sel = sel;
        u.ch = 8'h00;
        u.last = 1'b0;
        return u;
    endfunction

    function automatic t_uop script_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            6'd0: u = uop_b(CH_ESC, 1'b0);
            6'd1: u = uop_b(CH_LBRK, 1'b0);
            6'd2: u = uop_b(8'h6d, 1'b1);
            6'd3: u = uop_b(CH_ESC, 1'b0);
            6'd4: u = uop_b(CH_LBRK, 1'b0);
            6'd5: u = uop_n(NUM_ROW);
            6'd6: u = uop_b(CH_SEMI, 1'b0);
            6'd7: u = uop_n(NUM_COL);
            6'd8: u = uop_b(8'h48, 1'b1);
            6'd9: u = uop_b(CH_ESC, 1'b0);
            6'd10: u = uop_b(CH_LBRK, 1'b0);
            6'd11: u = uop_n(NUM_ROW);
            6'd12: u = uop_b(CH_SEMI, 1'b0);
            6'd13: u = uop_n(NUM_COL);
            6'd14: u = uop_b(8'h48, 1'b0);
            6'd15: u = uop_b(CH_ESC, 1'b0);
            6'd16: u = uop_b(CH_LBRK, 1'b0);
            6'd17: u = uop_n(NUM_STYLE);
            6'd18: u = uop_b(8'h20, 1'b0);
            6'd19: u = uop_b(8'h71, 1'b0);
            6'd20: u = uop_b(CH_ESC, 1'b0);
            6'd21: u = uop_b(CH_LBRK, 1'b0);
            6'd22: u = uop_b(8'h3f, 1'b0);
            6'd23: u = uop_b(8'h32, 1'b0);
            6'd24: u = uop_b(8'h35, 1'b0);
            6'd25: u = uop_b(8'h68, 1'b1);
            6'd26: u = uop_b(CH_ESC, 1'b0);
            6'd27: u = uop_b(CH_LBRK, 1'b0);
            6'd28: u = uop_b(8'h3f, 1'b0);
            6'd29: u = uop_b(8'h32, 1'b0);
            6'd30: u = uop_b(8'h35, 1'b0);
            6'd31: u = uop_b(8'h6c, 1'b1);
            6'd32: u = uop_b(CH_ESC, 1'b0);
            6'd33: u = uop_b(CH_LBRK, 1'b0);
            6'd34: u = uop_n(NUM_CCODE);
            6'd35: u = uop_b(8'h6d, 1'b1);
            6'd36: u = uop_b(CH_ESC, 1'b0);
            6'd37: u = uop_b(CH_LBRK, 1'b0);
            6'd38: u = uop_n(NUM_CCODE);
            6'd39: u = uop_b(CH_SEMI, 1'b0);
            6'd40: u = uop_b(8'h32, 1'b0);
            6'd41: u = uop_b(CH_SEMI, 1'b0);
            6'd42: u = uop_n(NUM_RED);
            6'd43: u = uop_b(CH_SEMI, 1'b0);
            6'd44: u = uop_n(NUM_GREEN);
            6'd45: u = uop_b(CH_SEMI, 1'b0);
            6'd46: u = uop_n(NUM_BLUE);
            6'd47: u = uop_b(8'h6d, 1'b1);
            6'd48: u = uop_b(CH_ESC, 1'b0);
            6'd49: u = uop_b(CH_LBRK, 1'b0);
            6'd50: u = uop_n(NUM_ATTR);
            6'd51: begin
                u = uop_b(8'h6d, 1'b0);
                u.kind = UOP_ATTR_M;
            end
            default: u = uop_b(8'h00, 1'b1);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/vtese_ctrl.sv
// controller state machine that walks the sequence script for one command
`timescale 1ns / 1ps
`default_nettype none

module vtese_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  vtese_pkg::t_dp_stat   i_stat,
    output vtese_pkg::t_dp_cmd    o_cmd
);

    vtese_pkg::t_state                            r_state, n_state;
    logic [vtese_pkg::PC_W-1:0]                   r_pc, n_pc;
    logic [vtese_pkg::ATTR_IDX_W-1:0]             r_attr_idx, n_attr_idx;
    vtese_pkg::t_uop                              uop;
    logic [vtese_pkg::ATTR_IDX_W-1:0]             first_idx;
    logic [vtese_pkg::ATTR_IDX_W-1:0]             next_idx;
    logic                                         more;

    assign uop = vtese_pkg::script_rom(r_pc);

    always_comb begin
        first_idx = '0;
        next_idx = '0;
        more = 1'b0;
        for (int k = vtese_pkg::ATTR_N - 1; k >= 0; k--) begin
            if (i_stat.diff[k]) begin
                first_idx = vtese_pkg::ATTR_IDX_W'(k);
                if (vtese_pkg::ATTR_IDX_W'(k) > r_attr_idx) begin
                    next_idx = vtese_pkg::ATTR_IDX_W'(k);
                    more = 1'b1;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        n_attr_idx = r_attr_idx;
        unique case (r_state)
            vtese_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = vtese_pkg::ST_DECODE;
                end
            end
            vtese_pkg::ST_DECODE: begin
                n_state = vtese_pkg::ST_RUN;
                unique case (i_stat.op)
                    vtese_pkg::OP_RESET: n_pc = vtese_pkg::PC_RESET;
                    vtese_pkg::OP_POSITION: n_pc = vtese_pkg::PC_POS;
                    vtese_pkg::OP_COLOR: begin
                        n_pc = i_stat.alpha_zero ? vtese_pkg::PC_CDEF : vtese_pkg::PC_CTRUE;
                    end
                    vtese_pkg::OP_ATTR: begin
                        n_pc = vtese_pkg::PC_ATTR;
                        n_attr_idx = first_idx;
                        if (i_stat.diff == '0) begin
                            n_state = vtese_pkg::ST_IDLE;
                        end
                    end
                    vtese_pkg::OP_SHOW: n_pc = vtese_pkg::PC_SHOW;
                    vtese_pkg::OP_HIDE: n_pc = vtese_pkg::PC_HIDE;
                    default: n_state = vtese_pkg::ST_IDLE;
                endcase
            end
            vtese_pkg::ST_RUN: begin
                unique case (uop.kind)
                    vtese_pkg::UOP_NUM: n_state = vtese_pkg::ST_CONV;
                    vtese_pkg::UOP_ATTR_M: begin
                        if (i_stat.out_free) begin
                            if (more) begin
                                n_attr_idx = next_idx;
                                n_pc = vtese_pkg::PC_ATTR;
                            end else begin
                                n_state = vtese_pkg::ST_IDLE;
                            end
                        end
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            if (uop.last) begin
                                n_state = vtese_pkg::ST_IDLE;
                            end else begin
                                n_pc = r_pc + 1'b1;
                            end
                        end
                    end
                endcase
            end
            vtese_pkg::ST_CONV: begin
                if (!i_stat.conv_busy) begin
                    n_state = vtese_pkg::ST_DIGITS;
                end
            end
            vtese_pkg::ST_DIGITS: begin
                if (i_stat.out_free && i_stat.dig_last) begin
                    n_pc = r_pc + 1'b1;
                    n_state = vtese_pkg::ST_RUN;
                end
            end
            default: n_state = vtese_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.num_sel = uop.sel;
        o_cmd.attr_idx = r_attr_idx;
        o_cmd.ch = uop.ch;
        o_in_ready = 1'b0;
        unique case (r_state)
            vtese_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            vtese_pkg::ST_RUN: begin
                unique case (uop.kind)
                    vtese_pkg::UOP_NUM: o_cmd.conv_start = 1'b1;
                    vtese_pkg::UOP_ATTR_M: begin
                        o_cmd.emit = i_stat.out_free;
                        o_cmd.last = !more;
                    end
                    default: begin
                        o_cmd.emit = i_stat.out_free;
                        o_cmd.last = uop.last;
                    end
                endcase
            end
            vtese_pkg::ST_DIGITS: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.emit_digit = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vtese_pkg::ST_IDLE;
            r_pc <= '0;
            r_attr_idx <= '0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
            r_attr_idx <= n_attr_idx;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/vtese_dp.sv
// datapath: command register, decimal converter and output byte register
`timescale 1ns / 1ps
`default_nettype none

module vtese_dp #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [79:0]           i_data,
    input  wire  [2:0]            i_op,
    input  vtese_pkg::t_dp_cmd    i_cmd,
    output vtese_pkg::t_dp_stat   o_stat,
    input  wire                   i_out_ready,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_last
);

    localparam int COORD_EFF = (COORD_WIDTH < vtese_pkg::NUM_W) ? COORD_WIDTH : vtese_pkg::NUM_W;
    localparam logic [vtese_pkg::NUM_W-1:0] COORD_MASK =
        vtese_pkg::NUM_W'((33'd1 << COORD_EFF) - 33'd1);
    localparam logic [32:0] RECIP10 = 33'd52429;

    logic [2:0]                  r_op;
    logic [15:0]                 r_row;
    logic [15:0]                 r_col;
    logic [2:0]                  r_style;
    logic                        r_fg;
    logic [7:0]                  r_red;
    logic [7:0]                  r_green;
    logic [7:0]                  r_blue;
    logic [7:0]                  r_alpha;
    logic [4:0]                  r_old_attrs;
    logic [4:0]                  r_new_attrs;

    logic [vtese_pkg::NUM_W-1:0]     r_val;
    logic [3:0]                      r_dig [vtese_pkg::DIG_N];
    logic [vtese_pkg::DIG_CNT_W-1:0] r_cnt;
    logic                            r_busy;
    logic                            r_out_valid;
    logic [7:0]                      r_out_byte;
    logic                            r_out_last;

    logic [vtese_pkg::NUM_W-1:0]     num_value;
    logic [7:0]                      color_code;
    logic [4:0]                      attr_code;
    logic [32:0]                     prod;
    logic [vtese_pkg::NUM_W-1:0]     quot;
    logic [vtese_pkg::NUM_W-1:0]     quot10;
    logic [vtese_pkg::NUM_W-1:0]     rem;
    logic [vtese_pkg::DIG_CNT_W-1:0] pop_idx;
    logic [7:0]                      digit_ch;
    logic                            out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_row <= i_data[15:0] & COORD_MASK;
            r_col <= i_data[31:16] & COORD_MASK;
            r_style <= i_data[34:32];
            r_fg <= i_data[35];
            r_red <= i_data[43:36];
            r_green <= i_data[51:44];
            r_blue <= i_data[59:52];
            r_alpha <= i_data[67:60];
            r_old_attrs <= i_data[72:68];
            r_new_attrs <= i_data[77:73];
        end
    end

    always_comb begin
        if (r_alpha == 8'd0) begin
            color_code = r_fg ? vtese_pkg::CODE_FG_DEF : vtese_pkg::CODE_BG_DEF;
        end else begin
            color_code = r_fg ? vtese_pkg::CODE_FG_TRUE : vtese_pkg::CODE_BG_TRUE;
        end
        attr_code = r_new_attrs[i_cmd.attr_idx] ? vtese_pkg::ATTR_ON_CODE[i_cmd.attr_idx]
                                                : vtese_pkg::ATTR_OFF_CODE[i_cmd.attr_idx];
    end

    always_comb begin
        unique case (i_cmd.num_sel)
            vtese_pkg::NUM_ROW: num_value = r_row;
            vtese_pkg::NUM_COL: num_value = r_col;
            vtese_pkg::NUM_STYLE: num_value = {13'd0, r_style};
            vtese_pkg::NUM_CCODE: num_value = {8'd0, color_code};
            vtese_pkg::NUM_RED: num_value = {8'd0, r_red};
            vtese_pkg::NUM_GREEN: num_value = {8'd0, r_green};
            vtese_pkg::NUM_BLUE: num_value = {8'd0, r_blue};
            vtese_pkg::NUM_ATTR: num_value = {11'd0, attr_code};
            default: num_value = '0;
        endcase
    end

    // divide by ten through the reciprocal, exact for all 16-bit values
    assign prod = {17'd0, r_val} * RECIP10;
    assign quot = {2'd0, prod[32:19]};
    assign quot10 = (quot << 3) + (quot << 1);
    assign rem = r_val - quot10;

    assign pop_idx = r_cnt - 1'b1;
    assign digit_ch = vtese_pkg::CH_ZERO + {4'd0, r_dig[pop_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.conv_start) begin
            r_busy <= 1'b1;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_busy <= (quot != '0);
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.emit && i_cmd.emit_digit) begin
            r_cnt <= pop_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.conv_start) begin
            r_val <= num_value;
        end else if (r_busy) begin
            r_val <= quot;
            r_dig[r_cnt] <= rem[3:0];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= i_cmd.emit_digit ? digit_ch : i_cmd.ch;
            r_out_last <= i_cmd.last;
        end
    end

    always_comb begin
        o_stat.op = r_op;
        o_stat.alpha_zero = (r_alpha == 8'd0);
        o_stat.diff = r_old_attrs ^ r_new_attrs;
        o_stat.out_free = out_free;
        o_stat.conv_busy = r_busy;
        o_stat.dig_last = (r_cnt == vtese_pkg::DIG_CNT_W'(1));
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;

endmodule

`default_nettype wire

FILE: hdl/vt_escape_sequence_encoder.sv
// top level of the vt escape sequence encoder
// usage:
//   slave channel takes one terminal command per transaction: tuser carries the
//   op code, tdata the operands. ready is high only while the block is idle.
//   master channel gives the escape sequence one byte per transaction with
//   tlast on the final byte of the command. ops that produce nothing (unused
//   codes, an attribute change with no difference) give no transaction.
// timing:
//   a command is accepted, decoded, then its literal bytes and decimal numbers
//   are emitted in script order; the divide-by-ten unit produces one digit per
//   cycle and the output register takes one byte per cycle while tready on the
//   master side is high. the longest commands (an attribute change that turns
//   all five attributes off, or a show at the largest coordinates) give 25 bytes.
//   the first byte passes the decode and run states and the output register.
// reset: synchronous, active low; the controller returns to idle and the
//   output register is emptied.
// stall: while tready on the master side is low the output register holds its
//   byte and the controller waits; no byte is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module vt_escape_sequence_encoder #(
    parameter int COORD_WIDTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // row[15:0] col[31:16] cursor_style[34:32] foreground[35] red[43:36]
    // green[51:44] blue[59:52] alpha[67:60] old_attrs[72:68] new_attrs[77:73]
    input  wire  [79:0] i_s_tdata,
    // op[2:0]
    input  wire  [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // out_byte[7:0]
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    vtese_pkg::t_dp_cmd  cmd;
    vtese_pkg::t_dp_stat stat;

    vtese_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vtese_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_s_tdata),
        .i_op        (i_s_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_byte  (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench for the vt escape sequence encoder: directed and random commands, byte-by-byte check
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [7:0] ESC_CHAR = 8'h1b;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_COMMANDS = 190;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] row;
        logic [15:0] col;
        logic [2:0]  style;
        logic        fg;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [4:0]  old_attrs;
        logic [4:0]  new_attrs;
    } t_command;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_seq_byte;

    class esc_seq_scoreboard;
        t_seq_byte  pending[$];
        logic [7:0] seq[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void add_text(string s);
            for (int i = 0; i < s.len(); i++) begin
                seq.push_back(s[i]);
            end
        endfunction

        function void add_csi();
            seq.push_back(ESC_CHAR);
            add_text("[");
        endfunction

        function void add_position(logic [15:0] row, logic [15:0] col);
            add_csi();
            add_text($sformatf("%0d;%0dH", row, col));
        endfunction

        function int unsigned sgr_code(int k, logic on);
            case (k)
                0: return on ? 1 : 22;
                1: return on ? 3 : 23;
                2: return on ? 4 : 24;
                3: return on ? 7 : 27;
                default: return on ? 9 : 29;
            endcase
        endfunction

        // builds the escape sequence of one command and queues its bytes
        function void note_command(t_command c);
            seq.delete();
            case (c.op)
                vtese_pkg::OP_RESET: begin
                    add_csi();
                    add_text("m");
                end
                vtese_pkg::OP_POSITION: begin
                    add_position(c.row, c.col);
                end
                vtese_pkg::OP_COLOR: begin
                    add_csi();
                    if (c.alpha == 8'd0) begin
                        add_text(c.fg ? "39m" : "49m");
                    end else begin
                        add_text(c.fg ? "38;2;" : "48;2;");
                        add_text($sformatf("%0d;%0d;%0dm", c.red, c.green, c.blue));
                    end
                end
                vtese_pkg::OP_ATTR: begin
                    for (int k = 0; k < 5; k++) begin
                        if (c.old_attrs[k] != c.new_attrs[k]) begin
                            add_csi();
                            add_text($sformatf("%0dm", sgr_code(k, c.new_attrs[k])));
                        end
                    end
                end
                vtese_pkg::OP_SHOW: begin
                    add_position(c.row, c.col);
                    add_csi();
                    add_text($sformatf("%0d q", c.style));
                    add_csi();
                    add_text("?25h");
                end
                vtese_pkg::OP_HIDE: begin
                    add_csi();
                    add_text("?25l");
                end
                default: begin
                end
            endcase
            foreach (seq[i]) begin
                pending.push_back('{ch: seq[i], last: (i == seq.size() - 1)});
            end
        endfunction

        task flag_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_byte(logic [7:0] ch, logic last);
            t_seq_byte exp_byte;
            if (pending.size() == 0) begin
                flag_mismatch($sformatf("byte %h with no byte expected", ch));
            end else begin
                exp_byte = pending.pop_front();
                if (ch !== exp_byte.ch) begin
                    flag_mismatch($sformatf("byte %h, expected %h", ch, exp_byte.ch));
                end
                if (last !== exp_byte.last) begin
                    flag_mismatch($sformatf("tlast %b, expected %b", last, exp_byte.last));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // row[15:0] col[31:16] cursor_style[34:32] foreground[35] red[43:36]
    // green[51:44] blue[59:52] alpha[67:60] old_attrs[72:68] new_attrs[77:73]
    logic [79:0] i_s_tdata = '0;
    // op[2:0]
    logic [2:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // out_byte[7:0]
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    esc_seq_scoreboard sb;
    bit steady_flow = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    vt_escape_sequence_encoder dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] random_coord();
        case ($urandom_range(4))
            0: return 16'($urandom_range(9));
            1: return 16'($urandom_range(99));
            2: return 16'($urandom_range(999));
            3: return 16'($urandom_range(9999));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_command random_command();
        t_command c;
        if ($urandom_range(99) < 6) begin
            c.op = ($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        end else begin
            c.op = 3'($urandom_range(5));
        end
        c.row = random_coord();
        c.col = random_coord();
        c.style = 3'($urandom_range(7));
        c.fg = 1'($urandom_range(1));
        c.red = 8'($urandom);
        c.green = 8'($urandom);
        c.blue = 8'($urandom);
        c.alpha = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
        c.old_attrs = 5'($urandom);
        c.new_attrs = ($urandom_range(7) == 0) ? c.old_attrs : 5'($urandom);
        return c;
    endfunction

    function automatic t_command make_command(logic [2:0] op);
        t_command c;
        c = random_command();
        c.op = op;
        return c;
    endfunction

    task automatic send_command(t_command c);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= c.op;
        i_s_tdata <= {2'b00, c.new_attrs, c.old_attrs, c.alpha, c.blue, c.green, c.red,
                      c.fg, c.style, c.col, c.row};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_command(c);
    endtask

    task automatic idle_sender(int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // sink side: check every accepted byte, stall at random or hold off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                sb.check_byte(o_m_tdata, o_m_tlast);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= steady_flow || ($urandom_range(99) >= 15);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        t_command c;
        int sent;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed commands
        send_command(make_command(vtese_pkg::OP_RESET));
        c = make_command(vtese_pkg::OP_POSITION);
        c.row = 16'd0;
        c.col = 16'd0;
        send_command(c);
        c = make_command(vtese_pkg::OP_POSITION);
        c.row = 16'hffff;
        c.col = 16'hffff;
        send_command(c);
        c = make_command(vtese_pkg::OP_POSITION);
        c.row = 16'd9;
        c.col = 16'd10;
        send_command(c);
        c = make_command(vtese_pkg::OP_COLOR);
        c.fg = 1'b1;
        c.alpha = 8'd0;
        send_command(c);
        c = make_command(vtese_pkg::OP_COLOR);
        c.fg = 1'b0;
        c.alpha = 8'd0;
        send_command(c);
        c = make_command(vtese_pkg::OP_COLOR);
        c.fg = 1'b1;
        c = '{op: vtese_pkg::OP_COLOR, row: c.row, col: c.col, style: c.style, fg: 1'b1,
              red: 8'hff, green: 8'hff, blue: 8'hff, alpha: 8'hff,
              old_attrs: c.old_attrs, new_attrs: c.new_attrs};
        send_command(c);
        c.fg = 1'b0;
        c.red = 8'd0;
        c.green = 8'd0;
        c.blue = 8'd0;
        c.alpha = 8'd1;
        send_command(c);
        c.fg = 1'b1;
        c.red = 8'd100;
        c.green = 8'd7;
        c.blue = 8'd42;
        c.alpha = 8'h80;
        send_command(c);
        c = make_command(vtese_pkg::OP_ATTR);
        c.old_attrs = 5'b00000;
        c.new_attrs = 5'b11111;
        send_command(c);
        c.old_attrs = 5'b11111;
        c.new_attrs = 5'b00000;
        send_command(c);
        c.old_attrs = 5'b00101;
        c.new_attrs = 5'b00101;
        send_command(c);
        c.old_attrs = 5'b10101;
        c.new_attrs = 5'b01010;
        send_command(c);
        c = make_command(vtese_pkg::OP_SHOW);
        c.row = 16'hffff;
        c.col = 16'hffff;
        c.style = 3'd7;
        send_command(c);
        c = make_command(vtese_pkg::OP_SHOW);
        c.row = 16'd0;
        c.col = 16'd0;
        c.style = 3'd0;
        send_command(c);
        c = make_command(vtese_pkg::OP_SHOW);
        c.row = 16'd1;
        c.col = 16'd12345;
        c.style = 3'd6;
        send_command(c);
        send_command(make_command(vtese_pkg::OP_HIDE));
        send_command(make_command(OP_SPARE_LO));
        send_command(make_command(OP_SPARE_HI));
        send_command(make_command(vtese_pkg::OP_RESET));

        // random commands
        sent = 0;
        while (sent < RANDOM_COMMANDS) begin
            steady_flow = (sent >= 100 && sent < 150);
            if (sent == 60) begin
                hold_request = 1'b1;
            end
            if (sent == 170) begin
                idle_sender(1);
                wait_drained();
            end
            if (!steady_flow && $urandom_range(99) < 15) begin
                idle_sender($urandom_range(1, 4));
            end
            c = random_command();
            send_command(c);
            sent++;
        end
        steady_flow = 1'b0;
        idle_sender(1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (sb.pending.size() != 0) begin
            sb.flag_mismatch($sformatf("byte %h never arrived", sb.pending[0].ch));
            void'(sb.pending.pop_front());
        end
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
